@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file uesr_checker.sv.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

@@ hdl/uesr_pkg.sv @@
// Shared types, codes and constants of the echo sweep ranger.
// No dependencies; imported by the interfaces and every module.
package uesr_pkg;

	localparam int CMD_W      = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int WORD_W     = 16;
	localparam int DIST_W     = 18;
	localparam int US_W       = 24;
	localparam int MUL_W      = 32;
	localparam int DIV_SHIFT  = 38;

	// Input commands
	typedef enum logic [CMD_W-1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_TICK   = 2'd1,
		CMD_MANUAL = 2'd2,
		CMD_UNUSED = 2'd3
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AUTO_TRIGGER   = 3'd0,
		REG_SWEEP_ENABLE   = 3'd1,
		REG_REVERSE_ORDER  = 3'd2,
		REG_POSITION_COUNT = 3'd3,
		REG_POSITION_STEP  = 3'd4,
		REG_MOVE_DELAY     = 3'd5,
		REG_RETURN_DELAY   = 3'd6,
		REG_STORE_BASE     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic              auto_trigger;
		logic              sweep_enable;
		logic              reverse_order;
		logic [WORD_W-1:0] position_count;
		logic [WORD_W-1:0] position_step;
		logic [WORD_W-1:0] move_delay;
		logic [WORD_W-1:0] return_delay;
		logic [WORD_W-1:0] store_base;
	} cfg_t;

	// Request to the shared serial multiplier
	typedef struct packed {
		logic             start;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mul_req_t;

	// Microseconds per sample count, Q16
	localparam logic [MUL_W-1:0] US_PER_COUNT_Q16 = 32'd1137778;
	// Speed of sound scale: mm = us * 170 / 1000
	localparam logic [MUL_W-1:0] MM_SCALE = 32'd170;
	// floor(x / 1000) = (x * DIV1000_RECIP) >> 38, exact for 32-bit x
	localparam logic [MUL_W-1:0] DIV1000_RECIP = 32'd274877907;
	// Result buffer size in bytes (up to 65536)
	localparam logic [WORD_W:0] STORE_SIZE = 17'd8192;
	localparam logic [DIST_W-1:0] DIST_MAX = 18'h3FFFF;

endpackage

@@ hdl/uesr_if.sv @@
// Valid/ready channel interfaces: echo items, results and config writes.
// Depends on uesr_pkg.
interface uesr_in_if import uesr_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CMD_W-1:0] command;
	logic             echo_level;

	modport source (output valid, command, echo_level, input ready);
	modport sink (input valid, command, echo_level, output ready);
endinterface

interface uesr_out_if import uesr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              trigger_pulse;
	logic              measure_valid;
	logic [WORD_W-1:0] high_counts;
	logic [DIST_W-1:0] distance_mm;
	logic [WORD_W-1:0] pulse_total;
	logic              store_enable;
	logic [WORD_W-1:0] store_address;
	logic [WORD_W-1:0] store_data;
	logic [WORD_W-1:0] servo_value;

	modport source (output valid, trigger_pulse, measure_valid, high_counts, distance_mm,
		pulse_total, store_enable, store_address, store_data, servo_value, input ready);
	modport sink (input valid, trigger_pulse, measure_valid, high_counts, distance_mm,
		pulse_total, store_enable, store_address, store_data, servo_value, output ready);
endinterface

interface uesr_cfg_if import uesr_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/uesr_cfg_regs.sv @@
// Configuration register file, written one beat at a time.
// Depends on uesr_pkg and uesr_cfg_if.
module uesr_cfg_regs import uesr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	uesr_cfg_if.sink   cfg_ch,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg = cfg_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_trigger   <= 1'b0;
			cfg_q.sweep_enable   <= 1'b0;
			cfg_q.reverse_order  <= 1'b0;
			cfg_q.position_count <= 16'd1;
			cfg_q.position_step  <= 16'd65535;
			cfg_q.move_delay     <= 16'd100;
			cfg_q.return_delay   <= 16'd500;
			cfg_q.store_base     <= 16'd0;
		end else if (cfg_ch.valid) begin
			case (cfg_reg_t'(cfg_ch.index))
				REG_AUTO_TRIGGER:   cfg_q.auto_trigger   <= cfg_ch.data[0];
				REG_SWEEP_ENABLE:   cfg_q.sweep_enable   <= cfg_ch.data[0];
				REG_REVERSE_ORDER:  cfg_q.reverse_order  <= cfg_ch.data[0];
				REG_POSITION_COUNT: cfg_q.position_count <= cfg_ch.data;
				REG_POSITION_STEP:  cfg_q.position_step  <= cfg_ch.data;
				REG_MOVE_DELAY:     cfg_q.move_delay     <= cfg_ch.data;
				REG_RETURN_DELAY:   cfg_q.return_delay   <= cfg_ch.data;
				REG_STORE_BASE:     cfg_q.store_base     <= cfg_ch.data;
				default:            cfg_q <= cfg_q;
			endcase
		end
	end

endmodule

@@ hdl/uesr_serial_mul.sv @@
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on uesr_pkg. Product valid in the cycle done is high.
module uesr_serial_mul import uesr_pkg::*; #(
	parameter int W = MUL_W
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mul_req_t       req,
	output logic           done,
	output logic [2*W-1:0] product
);

	localparam int CNT_W = $clog2(W);

	logic [W-1:0]     a_q;
	logic [W-1:0]     hi_q;
	logic [W-1:0]     lo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       sum;

	// One partial product added per step
	assign sum     = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : {(W+1){1'b0}});
	assign done    = done_q;
	assign product = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			hi_q   <= '0;
			lo_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				a_q    <= req.a[W-1:0];
				hi_q   <= '0;
				lo_q   <= req.b[W-1:0];
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				hi_q  <= sum[W:1];
				lo_q  <= {sum[0], lo_q[W-1:1]};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ hdl/ultrasonic_echo_sweep_ranger.sv @@
// Echo ranger: times the echo pulse, converts it to mm, sequences a servo sweep.
// Tick, manual and other samples: the beat goes from S_IDLE to S_EMIT, then to the result register.
// Falling edge: four passes through the serial multiplier (S_US, S_SCALE, S_DIV, S_SERVO), then S_EMIT.
// One item at a time; a new beat is taken as soon as the result is registered.
// Async active-low reset clears all state; config returns to its default values.
// Depends on uesr_pkg, uesr_if, uesr_cfg_regs, uesr_serial_mul.
module ultrasonic_echo_sweep_ranger import uesr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	uesr_in_if.sink    sample_ch,
	uesr_out_if.source result_ch,
	uesr_cfg_if.sink   cfg_ch
);

	typedef enum logic [2:0] {
		S_IDLE, S_US, S_SCALE, S_DIV, S_SERVO, S_EMIT
	} state_t;

	cfg_t               cfg;
	mul_req_t           mul_req;
	logic               mul_done;
	logic [2*MUL_W-1:0] mul_p;

	state_t             state_q;
	logic               mul_go_q;
	logic               level_q;
	logic [WORD_W-1:0]  run_q;
	logic [WORD_W-1:0]  held_hc_q;
	logic [DIST_W-1:0]  held_dist_q;
	logic [WORD_W-1:0]  pulse_q;
	logic [WORD_W-1:0]  pos_q;
	logic [WORD_W-1:0]  delay_q;
	logic               drain_q;
	logic               manual_q;
	logic [MUL_W-1:0]   tmp_q;
	logic               trig_q;
	logic               meas_q;
	logic               st_en_q;
	logic [WORD_W-1:0]  st_addr_q;
	logic [WORD_W-1:0]  servo_q;

	logic               out_valid_q;
	logic               o_trig_q;
	logic               o_meas_q;
	logic [WORD_W-1:0]  o_hc_q;
	logic [DIST_W-1:0]  o_dist_q;
	logic [WORD_W-1:0]  o_pulse_q;
	logic               o_st_en_q;
	logic [WORD_W-1:0]  o_st_addr_q;
	logic [WORD_W-1:0]  o_st_data_q;
	logic [WORD_W-1:0]  o_servo_q;

	logic               accept;
	cmd_t               cmd;
	logic               fall_edge;
	logic               trig_d;
	logic [WORD_W:0]    next_pos;
	logic [WORD_W-1:0]  addr_fwd;
	logic [WORD_W-1:0]  addr_rev;
	logic [WORD_W-1:0]  st_addr;
	logic [2*MUL_W-DIV_SHIFT-1:0] mm_raw;

	uesr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	uesr_serial_mul #(.W(MUL_W)) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.done    (mul_done),
		.product (mul_p)
	);

	assign sample_ch.ready = (state_q == S_IDLE);
	assign accept = sample_ch.valid && sample_ch.ready;
	assign cmd    = cmd_t'(sample_ch.command);

	// Falling edge of the echo on a sample outside a drained tick
	assign fall_edge = (cmd == CMD_SAMPLE) && !drain_q && !sample_ch.echo_level && level_q;

	// Trigger for this item: delay expiry or pending manual on a tick, else autotrigger
	assign trig_d = (cmd == CMD_TICK)
		? ((cfg.sweep_enable && delay_q != '0) ? (delay_q == 16'd1) : manual_q)
		: (fall_edge && cfg.auto_trigger && !cfg.sweep_enable);

	// Store address from the current sweep position
	assign next_pos = {1'b0, pos_q} + 17'd1;
	assign addr_fwd = cfg.store_base + {pos_q[WORD_W-2:0], 1'b0};
	assign addr_rev = cfg.store_base + {cfg.position_count[WORD_W-2:0], 1'b0} - 16'd2
		- {pos_q[WORD_W-2:0], 1'b0};
	assign st_addr  = cfg.reverse_order ? addr_rev : addr_fwd;

	// Quotient of the divide-by-1000 step
	assign mm_raw = mul_p[2*MUL_W-1:DIV_SHIFT];

	// Multiplier operand selection per sequencer step
	always_comb begin
		mul_req.start = mul_go_q;
		mul_req.a     = '0;
		mul_req.b     = '0;
		case (state_q)
			S_US: begin
				mul_req.a = US_PER_COUNT_Q16;
				mul_req.b = {{(MUL_W-WORD_W){1'b0}}, held_hc_q};
			end
			S_SCALE: begin
				mul_req.a = tmp_q;
				mul_req.b = MM_SCALE;
			end
			S_DIV: begin
				mul_req.a = tmp_q;
				mul_req.b = DIV1000_RECIP;
			end
			S_SERVO: begin
				mul_req.a = {{(MUL_W-WORD_W){1'b0}}, pos_q};
				mul_req.b = {{(MUL_W-WORD_W){1'b0}}, cfg.position_step};
			end
			default: begin
				mul_req.a = '0;
				mul_req.b = '0;
			end
		endcase
	end

	// Sequencer, ranging state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mul_go_q    <= 1'b0;
			level_q     <= 1'b0;
			run_q       <= '0;
			held_hc_q   <= '0;
			held_dist_q <= '0;
			pulse_q     <= '0;
			pos_q       <= '0;
			delay_q     <= '0;
			drain_q     <= 1'b0;
			manual_q    <= 1'b0;
			tmp_q       <= '0;
			trig_q      <= 1'b0;
			meas_q      <= 1'b0;
			st_en_q     <= 1'b0;
			st_addr_q   <= '0;
			servo_q     <= '0;
			out_valid_q <= 1'b0;
			o_trig_q    <= 1'b0;
			o_meas_q    <= 1'b0;
			o_hc_q      <= '0;
			o_dist_q    <= '0;
			o_pulse_q   <= '0;
			o_st_en_q   <= 1'b0;
			o_st_addr_q <= '0;
			o_st_data_q <= '0;
			o_servo_q   <= '0;
		end else begin
			// Multiplier start on a falling edge and after each of the first three passes
			mul_go_q <= (accept && fall_edge)
				|| ((state_q inside {S_US, S_SCALE, S_DIV}) && mul_done);
			if (result_ch.ready && state_q != S_EMIT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						trig_q    <= trig_d;
						meas_q    <= fall_edge;
						st_en_q   <= fall_edge && ({1'b0, st_addr} < STORE_SIZE);
						st_addr_q <= fall_edge ? st_addr : '0;
						servo_q   <= '0;
						state_q   <= fall_edge ? S_US : S_EMIT;
						case (cmd)
							CMD_TICK: begin
								if (cfg.sweep_enable && delay_q != '0) begin
									delay_q <= delay_q - 16'd1;
									drain_q <= 1'b1;
								end else begin
									drain_q <= 1'b0;
									if (manual_q) begin
										manual_q <= 1'b0;
									end
								end
							end
							CMD_MANUAL: begin
								manual_q <= 1'b1;
							end
							CMD_SAMPLE: begin
								if (!drain_q) begin
									if (sample_ch.echo_level) begin
										// rising edge restarts the run without counting
										run_q   <= level_q ? run_q + 16'd1 : '0;
										level_q <= 1'b1;
									end else if (level_q) begin
										// falling edge: latch, count, start conversion
										held_hc_q <= run_q;
										run_q     <= '0;
										level_q   <= 1'b0;
										pulse_q   <= pulse_q + 16'd1;
										if (next_pos >= {1'b0, cfg.position_count}) begin
											pos_q   <= '0;
											delay_q <= cfg.return_delay;
										end else begin
											pos_q   <= next_pos[WORD_W-1:0];
											delay_q <= cfg.move_delay;
										end
									end else begin
										run_q <= run_q + 16'd1;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_US: begin
					if (mul_done) begin
						tmp_q    <= {{(MUL_W-US_W){1'b0}}, mul_p[US_W+WORD_W-1:WORD_W]};
						state_q  <= S_SCALE;
					end
				end
				S_SCALE: begin
					if (mul_done) begin
						tmp_q    <= mul_p[MUL_W-1:0];
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (mul_done) begin
						held_dist_q <= (mm_raw > {{($bits(mm_raw)-DIST_W){1'b0}}, DIST_MAX})
							? DIST_MAX : mm_raw[DIST_W-1:0];
						state_q     <= S_SERVO;
					end
				end
				S_SERVO: begin
					if (mul_done) begin
						servo_q <= (mul_p[MUL_W-1:WORD_W] != '0) ? 16'hFFFF
							: mul_p[WORD_W-1:0];
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (!out_valid_q || result_ch.ready) begin
						out_valid_q <= 1'b1;
						o_trig_q    <= trig_q;
						o_meas_q    <= meas_q;
						o_hc_q      <= held_hc_q;
						o_dist_q    <= held_dist_q;
						o_pulse_q   <= pulse_q;
						o_st_en_q   <= st_en_q;
						o_st_addr_q <= st_addr_q;
						o_st_data_q <= meas_q ? held_dist_q[WORD_W-1:0] : '0;
						o_servo_q   <= servo_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_ch.valid         = out_valid_q;
	assign result_ch.trigger_pulse = o_trig_q;
	assign result_ch.measure_valid = o_meas_q;
	assign result_ch.high_counts   = o_hc_q;
	assign result_ch.distance_mm   = o_dist_q;
	assign result_ch.pulse_total   = o_pulse_q;
	assign result_ch.store_enable  = o_st_en_q;
	assign result_ch.store_address = o_st_addr_q;
	assign result_ch.store_data    = o_st_data_q;
	assign result_ch.servo_value   = o_servo_q;

endmodule

@@ hdl/uesr_checker.sv @@
// Port-level checks of the echo sweep ranger, bound to the top level.
// Depends on uesr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module uesr_checker import uesr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic              measure_valid,
	input logic              store_enable,
	input logic [WORD_W-1:0] store_address,
	input logic [WORD_W-1:0] servo_value
);

	// A stalled result beat stays offered
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// Each taken item makes the block busy: ready drops after the take
	`ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && in_ready, !in_ready)
	// A buffer write only comes with a measurement
	`ASSERT_IMPLY(a_store_needs_meas, clk, arst_n, out_valid && store_enable, measure_valid)
	// Without a measurement, store address and servo command are zero
	`ASSERT_IMPLY(a_idle_fields_zero, clk, arst_n, out_valid && !measure_valid,
		store_address == '0 && servo_value == '0)

endmodule

bind ultrasonic_echo_sweep_ranger uesr_checker u_uesr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (sample_ch.valid),
	.in_ready      (sample_ch.ready),
	.out_valid     (result_ch.valid),
	.out_ready     (result_ch.ready),
	.measure_valid (result_ch.measure_valid),
	.store_enable  (result_ch.store_enable),
	.store_address (result_ch.store_address),
	.servo_value   (result_ch.servo_value)
);
